FILE: src/cblm_pkg.sv
// ----------------------------------------------------------------------------
// cblm_pkg
// Shared types and constants of the cartridge bank latch mapper: access
// opcodes, controller-to-datapath command bundle, trigger window tags.
// ----------------------------------------------------------------------------
package cblm_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_CPU_READ  = 2'd0;
   localparam opcode_type OP_CPU_WRITE = 2'd1;
   localparam opcode_type OP_PPU_READ  = 2'd2;
   localparam opcode_type OP_PPU_WRITE = 2'd3;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_PRG_COUNT = 1'd0;
   localparam csr_index_type CSR_CHR_COUNT = 1'd1;

   // Register page select, bus_address[15:12] of a CPU write
   localparam logic [3:0] PAGE_PRG_SEL = 4'hA;
   localparam logic [3:0] PAGE_LO_FD   = 4'hB;
   localparam logic [3:0] PAGE_LO_FE   = 4'hC;
   localparam logic [3:0] PAGE_HI_FD   = 4'hD;
   localparam logic [3:0] PAGE_HI_FE   = 4'hE;
   localparam logic [3:0] PAGE_MIRROR  = 4'hF;

   // Latch trigger windows, bus_address[15:3] (8-byte aligned)
   localparam logic [12:0] TRIG_LO_FD = 13'h01FB;  // $0FD8-$0FDF
   localparam logic [12:0] TRIG_LO_FE = 13'h01FD;  // $0FE8-$0FEF
   localparam logic [12:0] TRIG_HI_FD = 13'h03FB;  // $1FD8-$1FDF
   localparam logic [12:0] TRIG_HI_FE = 13'h03FD;  // $1FE8-$1FEF

   typedef struct packed {
      logic load;   // capture the request beat
      logic exec;   // evaluate, update mapper state, load result register
   } cmd_type;

endpackage

FILE: src/cblm_ctrl.sv
// ----------------------------------------------------------------------------
// cblm_ctrl
// Two-state sequencer: take a request beat, then evaluate it once the
// result register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module cblm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cblm_pkg::cmd_type cmd
);
   import cblm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.load = req_valid && (state_ff == ST_IDLE);
      cmd.exec = (state_ff == ST_EXEC) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.exec) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat did not move to evaluation");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_EXEC))
      else $error("evaluation left while result register was full");

   a_exec_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("evaluated beat did not raise result valid");

endmodule

FILE: src/cblm_dp.sv
// ----------------------------------------------------------------------------
// cblm_dp
// Datapath: captured request, bank count registers, mapper state, shared
// bank remainder unit and the result register.
// ----------------------------------------------------------------------------
module cblm_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  cblm_pkg::cmd_type       cmd,
   input  cblm_pkg::opcode_type    req_opcode,
   input  logic [15:0]             req_bus_address,
   input  logic [7:0]              req_write_data,
   input  logic                    csr_write_enable,
   input  cblm_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_write_data,
   output logic                    rsp_handled,
   output logic                    rsp_address_valid,
   output logic [20:0]             rsp_mapped_address,
   output logic                    rsp_mirror_override,
   output logic                    rsp_mirror_horizontal
);
   import cblm_pkg::*;

   // captured request (payload, no reset)
   opcode_type  op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;

   // configuration
   logic [7:0] prg_count_ff, chr_count_ff;

   // mapper state
   logic [3:0] prg_sel_ff, prg_sel_in;
   logic [4:0] lo_fd_ff, lo_fd_in, lo_fe_ff, lo_fe_in;
   logic [4:0] hi_fd_ff, hi_fd_in, hi_fe_ff, hi_fe_in;
   logic       latch_lo_ff, latch_lo_in, latch_hi_ff, latch_hi_in;
   logic       mir_set_ff, mir_set_in, mir_hor_ff, mir_hor_in;

   // result register
   logic        handled_ff, handled_in;
   logic        avalid_ff, avalid_in;
   logic [20:0] mapped_ff, mapped_in;

   // remainder unit
   logic [4:0] dividend;
   logic [7:0] divisor;
   logic [4:0] remainder;
   logic [5:0] rem_acc;
   logic [5:0] rem_shift;

   logic [4:0] chr_bank;
   logic [7:0] prg_bank;

   always_comb begin
      chr_bank = addr_ff[12] ? (latch_hi_ff ? hi_fe_ff : hi_fd_ff)
                             : (latch_lo_ff ? lo_fe_ff : lo_fd_ff);
      if (op_ff == OP_CPU_READ) begin
         dividend = {1'b0, prg_sel_ff};
         divisor  = prg_count_ff;
      end else begin
         dividend = chr_bank;
         divisor  = chr_count_ff;
      end
   end

   // Restoring remainder, one dividend bit per step, five narrow steps
   always_comb begin
      rem_acc   = 6'd0;
      rem_shift = 6'd0;
      for (int i = 4; i >= 0; i--) begin
         rem_shift = {rem_acc[4:0], dividend[i]};
         if ({2'b00, rem_shift} >= divisor)
            rem_acc = 6'((8'(rem_shift) - divisor));
         else
            rem_acc = rem_shift;
      end
      remainder = rem_acc[4:0];
   end

   // Fixed windows: count-3, count-2, count-1, floored at zero
   always_comb begin
      unique case (addr_ff[14:13])
         2'b00: prg_bank = {3'b000, remainder};
         2'b01: prg_bank = (prg_count_ff >= 8'd3) ? (prg_count_ff - 8'd3) : 8'd0;
         2'b10: prg_bank = (prg_count_ff >= 8'd2) ? (prg_count_ff - 8'd2) : 8'd0;
         2'b11: prg_bank = (prg_count_ff >= 8'd1) ? (prg_count_ff - 8'd1) : 8'd0;
         default: prg_bank = 8'd0;
      endcase
   end

   always_comb begin
      prg_sel_in  = prg_sel_ff;
      lo_fd_in    = lo_fd_ff;
      lo_fe_in    = lo_fe_ff;
      hi_fd_in    = hi_fd_ff;
      hi_fe_in    = hi_fe_ff;
      latch_lo_in = latch_lo_ff;
      latch_hi_in = latch_hi_ff;
      mir_set_in  = mir_set_ff;
      mir_hor_in  = mir_hor_ff;
      handled_in  = 1'b0;
      avalid_in   = 1'b0;
      mapped_in   = 21'd0;
      unique case (op_ff)
         OP_CPU_READ: begin
            if (addr_ff[15] && (prg_count_ff != 8'd0)) begin
               handled_in = 1'b1;
               avalid_in  = 1'b1;
               mapped_in  = {prg_bank, addr_ff[12:0]};
            end
         end
         OP_CPU_WRITE: begin
            if (addr_ff[15]) begin
               handled_in = 1'b1;
               unique case (addr_ff[15:12])
                  PAGE_PRG_SEL: prg_sel_in = data_ff[3:0];
                  PAGE_LO_FD:   lo_fd_in   = data_ff[4:0];
                  PAGE_LO_FE:   lo_fe_in   = data_ff[4:0];
                  PAGE_HI_FD:   hi_fd_in   = data_ff[4:0];
                  PAGE_HI_FE:   hi_fe_in   = data_ff[4:0];
                  PAGE_MIRROR: begin
                     mir_set_in = 1'b1;
                     mir_hor_in = data_ff[0];
                  end
                  default: ;
               endcase
            end
         end
         OP_PPU_READ: begin
            if ((addr_ff[15:13] == 3'b000) && (chr_count_ff != 8'd0)) begin
               handled_in = 1'b1;
               avalid_in  = 1'b1;
               mapped_in  = {4'b0000, remainder, addr_ff[11:0]};
               if (addr_ff[15:3] == TRIG_LO_FD) latch_lo_in = 1'b0;
               else if (addr_ff[15:3] == TRIG_LO_FE) latch_lo_in = 1'b1;
               else if (addr_ff[15:3] == TRIG_HI_FD) latch_hi_in = 1'b0;
               else if (addr_ff[15:3] == TRIG_HI_FE) latch_hi_in = 1'b1;
            end
         end
         OP_PPU_WRITE: begin
            if ((addr_ff[15:13] == 3'b000) && (chr_count_ff == 8'd0)) begin
               handled_in = 1'b1;
               avalid_in  = 1'b1;
               mapped_in  = {5'b00000, addr_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         addr_ff <= req_bus_address;
         data_ff <= req_write_data;
      end
      if (cmd.exec) begin
         handled_ff <= handled_in;
         avalid_ff  <= avalid_in;
         mapped_ff  <= mapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= 8'd0;
         chr_count_ff <= 8'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PRG_COUNT: prg_count_ff <= csr_write_data;
            CSR_CHR_COUNT: chr_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_sel_ff  <= 4'd0;
         lo_fd_ff    <= 5'd0;
         lo_fe_ff    <= 5'd0;
         hi_fd_ff    <= 5'd0;
         hi_fe_ff    <= 5'd0;
         latch_lo_ff <= 1'b0;
         latch_hi_ff <= 1'b0;
         mir_set_ff  <= 1'b0;
         mir_hor_ff  <= 1'b0;
      end else if (cmd.exec) begin
         prg_sel_ff  <= prg_sel_in;
         lo_fd_ff    <= lo_fd_in;
         lo_fe_ff    <= lo_fe_in;
         hi_fd_ff    <= hi_fd_in;
         hi_fe_ff    <= hi_fe_in;
         latch_lo_ff <= latch_lo_in;
         latch_hi_ff <= latch_hi_in;
         mir_set_ff  <= mir_set_in;
         mir_hor_ff  <= mir_hor_in;
      end
   end

   // mirror fields report the state after this access
   assign rsp_handled           = handled_ff;
   assign rsp_address_valid     = avalid_ff;
   assign rsp_mapped_address    = mapped_ff;
   assign rsp_mirror_override   = mir_set_ff;
   assign rsp_mirror_horizontal = mir_hor_ff;

   a_latch_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> ($stable(latch_lo_ff) && $stable(latch_hi_ff)))
      else $error("character latch moved without an evaluated beat");

   a_mirror_sticky: assert property (@(posedge clock) disable iff (reset)
      mir_set_ff |=> mir_set_ff)
      else $error("mirror override flag dropped");

endmodule

FILE: src/cartridge_bank_latch_mapper_unit.sv
// Latency: an accepted beat is captured, then evaluated into the response
//   register. Throughput: the sequencer's capture and evaluation steps set it;
//   no new beat is taken before the held one is evaluated. A held response
//   stalls the next evaluation; the request side stays closed until it runs.
// Reset: synchronous, active high; clears bank counts, bank registers, latches
//   (FD selected), mirroring flags and all handshake state. No clearing pass.
// ----------------------------------------------------------------------------
// cartridge_bank_latch_mapper_unit
// Bank mapper with FD/FE latched character banks. Each request beat is one
// bus access (CPU/PPU read/write); each produces exactly one response beat.
// ----------------------------------------------------------------------------
module cartridge_bank_latch_mapper_unit (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cblm_pkg::opcode_type    req_opcode,
   input  logic [15:0]             req_bus_address,
   input  logic [7:0]              req_write_data,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_handled,
   output logic                    rsp_address_valid,
   output logic [20:0]             rsp_mapped_address,
   output logic                    rsp_mirror_override,
   output logic                    rsp_mirror_horizontal,
   // configuration write port
   input  logic                    csr_write_enable,
   input  cblm_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_write_data
);
   import cblm_pkg::*;

   // Command bundle from the sequencer: load captures the beat, exec
   // evaluates it and commits state plus response in the same edge.
   cmd_type cmd;

   // Sequencer: ready only when no beat is held; evaluate only when the
   // response register is empty or draining this cycle.
   cblm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: one shared bank remainder unit serves both the program
   // switchable window and the character halves; latches advance after
   // the bank is chosen.
   cblm_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_opcode            (req_opcode),
      .req_bus_address       (req_bus_address),
      .req_write_data        (req_write_data),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_handled           (rsp_handled),
      .rsp_address_valid     (rsp_address_valid),
      .rsp_mapped_address    (rsp_mapped_address),
      .rsp_mirror_override   (rsp_mirror_override),
      .rsp_mirror_horizontal (rsp_mirror_horizontal)
   );

   // A blocked ROM write never carries a meaningful address
   a_valid_needs_claim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_address_valid) |-> rsp_handled)
      else $error("address valid on an unclaimed access");

endmodule
